@@ rtl/codebook_dense_layer_mac_defines.svh @@
// Assertion macros used by the checker file.
`ifndef CODEBOOK_DENSE_LAYER_MAC_DEFINES_SVH
`define CODEBOOK_DENSE_LAYER_MAC_DEFINES_SVH

// Consequent must hold at the same edge as the antecedent.
`define CDLM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdlm assertion failed");

// Consequent must hold at the edge after the antecedent.
`define CDLM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdlm assertion failed");

`endif

@@ rtl/cdlm_pkg.sv @@
`default_nettype none

package cdlm_pkg;

    localparam int BITS_PER_INDEX   = 2;
    localparam int INDEXES_PER_WORD = 8;
    localparam int MAX_INPUTS       = 1024;

    localparam int DATA_W    = 16;
    localparam int WORD_W    = 16;
    localparam int ADDR_W    = $clog2(MAX_INPUTS);
    localparam int LEN_W     = 11;
    localparam int ROW_W     = 16;
    localparam int ACC_W     = 48;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int CB_DEPTH  = 4;
    localparam int CB_SEL_W  = $clog2(CB_DEPTH);
    localparam int KCNT_W    = $clog2(INDEXES_PER_WORD + 1);
    localparam int SHIFT_W   = $clog2(WORD_W);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic CMD_ACTIVATION = 1'b0;
    localparam logic CMD_INDEX_WORD = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_W0,
        CFG_W1,
        CFG_W2,
        CFG_W3,
        CFG_IN_LENGTH,
        CFG_ROW_COUNT
    } cfg_idx_t;

    typedef struct packed {
        logic                     cmd;
        logic signed [DATA_W-1:0] activation;
        logic [WORD_W-1:0]        index_word;
        logic signed [DATA_W-1:0] row_bias;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] row_result;
        logic [ROW_W-1:0]         row_number;
        logic                     final_row;
    } out_item_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/codebook_dense_layer_mac.sv @@
// Codebook dense layer: one shared multiply-accumulate per packed index.
// Input channel in_valid / in_stall / in_data: an activation beat (cmd 0)
// writes the next activation store entry; the block is ready again on the
// following cycle. An index word beat (cmd 1) is worked one index per cycle
// through the shared multiplier, up to 8 indexes, then in_stall holds while
// the store read and the multiply/accumulate pipeline drain. A word that
// ends a row then shifts, adds the bias and saturates, and loads the result
// register once it is free, which raises out_valid. The block takes no new
// beat until it is through with an index word, as set by the single
// multiply-accumulate unit, its pipeline drain and the one store read port.
// Output channel out_valid / out_stall / out_data: the result register
// holds while out_stall is high; a new word is still accepted meanwhile,
// and only a row end waits for the register to free up.
// Configuration writes (cfg_we / cfg_index / cfg_data) take effect at once;
// the user must make them while the block is idle, and the block itself does
// not enforce this. Reset clears the pointers, the accumulator and the row
// counter; the activation store is not cleared.
`default_nettype none

module codebook_dense_layer_mac
    import cdlm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SUM_W = ACC_W - 7;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t                     state_reg;
    logic [WORD_W-1:0]          word_reg;
    logic signed [DATA_W-1:0]   bias_reg;
    logic [KCNT_W-1:0]          k_reg;
    logic [LEN_W-1:0]           use_ptr_reg;
    logic [ADDR_W-1:0]          load_ptr_reg;
    logic [ROW_W-1:0]           row_cnt_reg;
    logic                       rd_valid_reg;
    logic signed [DATA_W-1:0]   wsel_reg;
    logic                       out_valid_reg;
    out_item_t                  out_data_reg;

    logic signed [DATA_W-1:0]   cb_reg [CB_DEPTH];
    logic [LEN_W-1:0]           in_len_reg;
    logic [ROW_W-1:0]           row_count_reg;

    logic                       in_accept;
    logic                       can_issue;
    logic                       last_issue;
    logic [SHIFT_W-1:0]         shift_amt;
    logic [BITS_PER_INDEX-1:0]  idx;
    logic [DATA_W-1:0]          rd_data;
    logic                       mac_busy;
    logic signed [ACC_W-1:0]    acc;
    mac_ctrl_t                  mac_ctrl;
    logic                       out_free;
    logic                       row_last;
    logic signed [SUM_W-1:0]    sum;
    logic signed [DATA_W-1:0]   sat;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign can_issue  = (k_reg != KCNT_W'(INDEXES_PER_WORD)) && (use_ptr_reg < in_len_reg);
    assign last_issue = (k_reg == KCNT_W'(INDEXES_PER_WORD - 1))
                     || (({1'b0, use_ptr_reg} + (LEN_W+1)'(1)) >= {1'b0, in_len_reg});
    assign shift_amt  = SHIFT_W'(k_reg * BITS_PER_INDEX);
    assign idx        = BITS_PER_INDEX'(word_reg >> shift_amt);

    assign out_free = !out_valid_reg || !out_stall;

    assign mac_ctrl.valid = rd_valid_reg;
    assign mac_ctrl.clear = (state_reg == S_FINISH) && out_free;

    // Floor divide by 256 is an arithmetic shift; then add the bias and clamp.
    assign sum = $signed({acc[ACC_W-1], acc[ACC_W-1:8]})
               + $signed({{(SUM_W-DATA_W){bias_reg[DATA_W-1]}}, bias_reg});

    always_comb
    begin
        if (sum > SAT_MAX)
        begin
            sat = DATA_W'(SAT_MAX);
        end
        else if (sum < SAT_MIN)
        begin
            sat = DATA_W'(SAT_MIN);
        end
        else
        begin
            sat = sum[DATA_W-1:0];
        end
    end

    assign row_last = (({1'b0, row_cnt_reg} + (ROW_W+1)'(1)) >= {1'b0, row_count_reg});

    cdlm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_INPUTS)
    ) u_act_ram (
        .clk   (clk),
        .we    (in_accept && (in_data.cmd == CMD_ACTIVATION)),
        .waddr (load_ptr_reg),
        .wdata (in_data.activation),
        .re    ((state_reg == S_MAC) && can_issue),
        .raddr (use_ptr_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    cdlm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .weight (wsel_reg),
        .act    ($signed(rd_data)),
        .busy   (mac_busy),
        .acc    (acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CB_DEPTH; i++)
            begin
                cb_reg[i] <= '0;
            end
            in_len_reg    <= LEN_W'(1);
            row_count_reg <= ROW_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_W0, CFG_W1, CFG_W2, CFG_W3:
                    cb_reg[CB_SEL_W'(cfg_index)] <= cfg_data;
                CFG_IN_LENGTH:
                    in_len_reg <= cfg_data[LEN_W-1:0];
                CFG_ROW_COUNT:
                    row_count_reg <= cfg_data[ROW_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            use_ptr_reg   <= '0;
            load_ptr_reg  <= '0;
            row_cnt_reg   <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            word_reg      <= '0;
            bias_reg      <= '0;
            wsel_reg      <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            rd_valid_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (in_data.cmd == CMD_INDEX_WORD)
                        begin
                            word_reg  <= in_data.index_word;
                            bias_reg  <= in_data.row_bias;
                            k_reg     <= '0;
                            state_reg <= S_MAC;
                        end
                        else
                        begin
                            load_ptr_reg <= load_ptr_reg + ADDR_W'(1);
                        end
                    end
                end
                S_MAC:
                begin
                    if (can_issue)
                    begin
                        rd_valid_reg <= 1'b1;
                        wsel_reg     <= cb_reg[CB_SEL_W'(idx)];
                        use_ptr_reg  <= use_ptr_reg + LEN_W'(1);
                        k_reg        <= k_reg + KCNT_W'(1);
                        if (last_issue)
                        begin
                            state_reg <= S_DRAIN;
                        end
                    end
                    else
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    // Wait for the read and multiply stages to empty.
                    if (!rd_valid_reg && !mac_busy)
                    begin
                        if (use_ptr_reg >= in_len_reg)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg           <= 1'b1;
                        out_data_reg.row_result <= sat;
                        out_data_reg.row_number <= row_cnt_reg;
                        out_data_reg.final_row  <= row_last;
                        use_ptr_reg             <= '0;
                        if (row_last)
                        begin
                            row_cnt_reg  <= '0;
                            load_ptr_reg <= '0;
                        end
                        else
                        begin
                            row_cnt_reg <= row_cnt_reg + ROW_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/cdlm_ram.sv @@
`default_nettype none

module cdlm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/cdlm_mac.sv @@
`default_nettype none

module cdlm_mac
    import cdlm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mac_ctrl_t                ctrl,
    input  wire logic signed [DATA_W-1:0] weight,
    input  wire logic signed [DATA_W-1:0] act,
    output logic                          busy,
    output logic signed [ACC_W-1:0]       acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // Multiply into a register, accumulate on the next edge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctrl.valid;
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            prod_reg <= weight * act;
        end
    end

    assign busy = prod_valid_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

@@ rtl/cdlm_checker.sv @@
`default_nettype none
`include "codebook_dense_layer_mac_defines.svh"

module cdlm_checker
    import cdlm_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire in_item_t              in_data,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire out_item_t             out_data,
    input wire logic                  cfg_we,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    // A stalled result holds.
    `CDLM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // An index word always occupies the unit, so the input stalls once it is accepted.
    `CDLM_ASSERT_NEXT(a_word_busy, in_valid && !in_stall && (in_data.cmd == CMD_INDEX_WORD), in_stall)

    // An activation beat never blocks the next beat.
    `CDLM_ASSERT_NEXT(a_act_ready, in_valid && !in_stall && (in_data.cmd == CMD_ACTIVATION), !in_stall)

    // A new result only appears at the end of index word work.
    `CDLM_ASSERT_SAME(a_result_src, $rose(out_valid), $past(in_stall))

endmodule

bind codebook_dense_layer_mac cdlm_checker u_cdlm_checker (.*);

`default_nettype wire

@@ test/codebook_dense_layer_mac_tb.sv @@
`timescale 1ns / 100ps

module codebook_dense_layer_mac_tb;
    import cdlm_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES   = 40;
    localparam int RANDOM_BEATS  = 260;
    localparam int HOLD_CYCLES   = 300;

    // Tracks the layer state and keeps the row results still owed by the block.
    class layer_row_checker;
        logic signed [DATA_W-1:0] weights [0:CB_DEPTH-1];
        logic [LEN_W-1:0]         in_len;
        logic [ROW_W-1:0]         row_cnt;
        logic signed [DATA_W-1:0] act_mem [0:MAX_INPUTS-1];
        bit                       written [0:MAX_INPUTS-1];
        logic [ADDR_W-1:0]        load_ptr;
        logic [LEN_W-1:0]         use_ptr;
        longint                   acc;
        logic [ROW_W-1:0]         row_ctr;
        out_item_t                owed_rows [$];
        int                       mismatches;
        int                       rows_checked;

        function new();
            int i;
            for (i = 0; i < CB_DEPTH; i++)
                weights[i] = '0;
            in_len = LEN_W'(1);
            row_cnt = ROW_W'(1);
            load_ptr = '0;
            use_ptr = '0;
            acc = 0;
            row_ctr = '0;
            mismatches = 0;
            rows_checked = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_W0, CFG_W1, CFG_W2, CFG_W3: weights[int'(idx)] = v;
                CFG_IN_LENGTH: in_len = v[LEN_W-1:0];
                CFG_ROW_COUNT: row_cnt = v[ROW_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_rows.size();
        endfunction

        // True when the next index word only reads store entries already loaded.
        function bit word_reads_ok();
            logic [LEN_W-1:0] u;
            int k;
            u = use_ptr;
            for (k = 0; k < INDEXES_PER_WORD && u < in_len; k++) begin
                if (!written[u[ADDR_W-1:0]])
                    return 1'b0;
                u = u + LEN_W'(1);
            end
            return 1'b1;
        endfunction

        function void note_beat(in_item_t it);
            out_item_t want;
            logic [CB_SEL_W-1:0] sel;
            longint sum;
            int k;
            bit last;
            if (it.cmd == CMD_ACTIVATION) begin
                act_mem[load_ptr] = it.activation;
                written[load_ptr] = 1'b1;
                load_ptr = load_ptr + ADDR_W'(1);
                return;
            end
            for (k = 0; k < INDEXES_PER_WORD && use_ptr < in_len; k++) begin
                sel = it.index_word[k*BITS_PER_INDEX +: BITS_PER_INDEX];
                acc += longint'($signed(weights[sel])) *
                       longint'($signed(act_mem[use_ptr[ADDR_W-1:0]]));
                use_ptr = use_ptr + LEN_W'(1);
            end
            if (use_ptr < in_len)
                return;
            // floor the Q16.16 sum back to Q8.8, add bias, clamp
            sum = (acc >>> 8) + longint'($signed(it.row_bias));
            if (sum > 32767)
                sum = 32767;
            else if (sum < -32768)
                sum = -32768;
            last = (int'(row_ctr) + 1) >= int'(row_cnt);
            want.row_result = sum[DATA_W-1:0];
            want.row_number = row_ctr;
            want.final_row  = last;
            owed_rows.push_back(want);
            acc = 0;
            use_ptr = '0;
            if (last) begin
                row_ctr = '0;
                load_ptr = '0;
            end
            else begin
                row_ctr = row_ctr + ROW_W'(1);
            end
        endfunction

        function void check_row(out_item_t got);
            out_item_t want;
            if (owed_rows.size() == 0) begin
                $display("%0t: row result with none owed: result %0d row %0d final %0d",
                         $time, $signed(got.row_result), got.row_number, got.final_row);
                mismatches++;
                return;
            end
            want = owed_rows.pop_front();
            rows_checked++;
            if (got.row_result !== want.row_result) begin
                $display("%0t: row_result mismatch: expected %0d actual %0d", $time,
                         $signed(want.row_result), $signed(got.row_result));
                mismatches++;
            end
            if (got.row_number !== want.row_number) begin
                $display("%0t: row_number mismatch: expected %0d actual %0d", $time,
                         want.row_number, got.row_number);
                mismatches++;
            end
            if (got.final_row !== want.final_row) begin
                $display("%0t: final_row mismatch: expected %0d actual %0d", $time,
                         want.final_row, got.final_row);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    layer_row_checker rows;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  cycle_count = 0;
    int  beats = 0;
    int  act_beats = 0;
    int  word_beats = 0;
    int  phases = 0;

    codebook_dense_layer_mac u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Result side: check accepted beats, then pick the stall for the next edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            rows.check_row(out_data);
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d row results still owed",
                 cycle_count, rows.pending());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_item_t make_activation(logic [DATA_W-1:0] v);
        in_item_t it;
        it.cmd        = CMD_ACTIVATION;
        it.activation = v;
        it.index_word = 16'($urandom);
        it.row_bias   = 16'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_word(logic [WORD_W-1:0] w, logic [DATA_W-1:0] bias);
        in_item_t it;
        it.cmd        = CMD_INDEX_WORD;
        it.activation = 16'($urandom);
        it.index_word = w;
        it.row_bias   = bias;
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rows.note_beat(it);
        beats++;
        if (it.cmd == CMD_ACTIVATION)
            act_beats++;
        else
            word_beats++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        rows.set_reg(idx, v);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for every owed row, then let an unfinished word run out.
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        while (rows.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Load an activation instead when the word would read an unloaded entry.
    task automatic send_guarded_word();
        if (rows.word_reads_ok())
            send_item(make_word(16'($urandom), pick_value()));
        else
            send_item(make_activation(pick_value()));
    endtask

    task automatic randomize_regs();
        int i;
        int pick;
        logic [CFG_DATA_W-1:0] len;
        logic [CFG_DATA_W-1:0] cnt;
        for (i = 0; i < CB_DEPTH; i++)
            write_reg(cfg_idx_t'(i), pick_value());
        pick = $urandom_range(0, 19);
        if (pick == 0)
            len = '0;
        else if (pick == 1)
            len = 16'd1;
        else if (pick == 2)
            len = 16'($urandom_range(41, 200));
        else
            len = 16'($urandom_range(2, 40));
        pick = $urandom_range(0, 19);
        if (pick < 2)
            cnt = '0;
        else if (pick == 2)
            cnt = 16'hFFFF;
        else
            cnt = 16'($urandom_range(1, 6));
        write_reg(CFG_IN_LENGTH, len);
        write_reg(CFG_ROW_COUNT, cnt);
    endtask

    // One layer: load the activations, then the index words of each row.
    task automatic run_layer();
        int n_rows;
        int n_words;
        int i;
        int r;
        for (i = 0; i < int'(rows.in_len); i++)
            send_item(make_activation(pick_value()));
        if (rows.row_cnt >= 1 && rows.row_cnt <= 6)
            n_rows = int'(rows.row_cnt);
        else
            n_rows = $urandom_range(1, 3);
        n_words = (rows.in_len == 0) ? 1 : (int'(rows.in_len) + 7) / 8;
        for (r = 0; r < n_rows; r++)
            for (i = 0; i < n_words; i++)
                send_guarded_word();
    endtask

    initial
    begin
        int i;
        int rand_start;
        int progress;
        int phase_end;
        bit noisy;

        rows = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: saturation both ways, ignored tail indexes, extreme values.
        send_idle_pct = 10;
        recv_stall_pct = 30;
        write_reg(CFG_W0, 16'h7FFF);
        write_reg(CFG_W1, 16'h8000);
        write_reg(CFG_W2, 16'h0100);
        write_reg(CFG_W3, 16'hFF00);
        write_reg(CFG_IN_LENGTH, 16'd3);
        write_reg(CFG_ROW_COUNT, 16'd2);
        send_item(make_activation(16'h7FFF));
        send_item(make_activation(16'h8000));
        send_item(make_activation(16'h0001));
        send_item(make_word(16'hFFE4, 16'h7FFF));
        send_item(make_word(16'hFFF1, 16'h8000));

        // Zero row length, every row final.
        drain(SETTLE_CYCLES);
        write_reg(CFG_IN_LENGTH, 16'd0);
        write_reg(CFG_ROW_COUNT, 16'd0);
        send_item(make_word(16'h0000, 16'h1234));
        send_item(make_word(16'hFFFF, 16'hFFFF));

        // Row length lowered below the pointer in the middle of a row.
        drain(SETTLE_CYCLES);
        write_reg(CFG_IN_LENGTH, 16'd12);
        write_reg(CFG_ROW_COUNT, 16'hFFFF);
        send_item(make_activation(16'h0000));
        send_item(make_activation(16'h7FFF));
        send_item(make_activation(16'h8000));
        send_item(make_activation(16'hFFFF));
        send_item(make_activation(16'h0001));
        send_item(make_activation(16'h0100));
        send_item(make_activation(16'hFF00));
        send_item(make_activation(16'h1234));
        send_item(make_word(16'hFFFF, pick_value()));
        drain(SETTLE_CYCLES);
        write_reg(CFG_IN_LENGTH, 16'd5);
        send_item(make_word(16'h5555, 16'h0000));
        send_item(make_word(16'h0000, 16'h0080));

        // Random phases.
        rand_start = beats;
        while (beats - rand_start < RANDOM_BEATS || phases < 4)
        begin
            progress = beats - rand_start;
            if (progress < RANDOM_BEATS / 3)
            begin
                send_idle_pct = 25;
                recv_stall_pct = 85;
            end
            else if (progress < 2 * RANDOM_BEATS / 3)
            begin
                send_idle_pct = 85;
                recv_stall_pct = 25;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            drain(SETTLE_CYCLES);
            randomize_regs();
            if (phases == 1)
            begin
                // Short rows, three per layer, so a held result backs up the input.
                write_reg(CFG_IN_LENGTH, 16'd16);
                write_reg(CFG_ROW_COUNT, 16'd3);
                hold_req = 1'b1;
            end
            phase_end = beats + $urandom_range(20, 50);
            noisy = (phases != 1 && phases != 3 && $urandom_range(0, 4) == 0);
            if (phases == 3)
            begin
                run_layer();
                drain(1);
            end
            while (beats < phase_end)
            begin
                if (noisy)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_item(make_activation(pick_value()));
                    else
                        send_guarded_word();
                end
                else
                begin
                    run_layer();
                end
            end
            phases++;
        end

        // Full store, then a row length past the store size so reads wrap.
        send_idle_pct = 10;
        recv_stall_pct = 40;
        drain(SETTLE_CYCLES);
        for (i = 0; i < CB_DEPTH; i++)
            write_reg(cfg_idx_t'(i), pick_value());
        write_reg(CFG_IN_LENGTH, 16'd1030);
        write_reg(CFG_ROW_COUNT, 16'd2);
        for (i = 0; i < MAX_INPUTS; i++)
            send_item(make_activation(pick_value()));
        for (i = 0; i < 129; i++)
            send_guarded_word();
        phases++;

        drain(TAIL_CYCLES);
        $display("%0d beats (%0d activations, %0d index words) over %0d phases, %0d rows checked",
                 beats, act_beats, word_beats, phases, rows.rows_checked);
        $display("ran saturation, zero and lowered row length, wrapped reads and long stalls");
        if (rows.mismatches == 0 && rows.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cdlm_pkg.sv
rtl/cdlm_ram.sv
rtl/cdlm_mac.sv
rtl/codebook_dense_layer_mac.sv
rtl/cdlm_checker.sv
test/codebook_dense_layer_mac_tb.sv
